### hw/rtl/urf_pkg.sv
// Types and constants shared by the UDP port receive filter modules.
`timescale 1ns / 1ps

package urf_pkg;

   localparam int POS_W      = 11;
   localparam int COUNT_W    = 11;
   localparam int PORT_W     = 16;
   localparam int IP_W       = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [POS_W-1:0] POS_LIMIT          = 11'd2047;
   localparam logic [POS_W-1:0] POS_ETH_HI         = 11'd12;
   localparam logic [POS_W-1:0] POS_ETH_LO         = 11'd13;
   localparam logic [POS_W-1:0] POS_PROTO          = 11'd23;
   localparam logic [POS_W-1:0] POS_SRC_IP_FIRST   = 11'd26;
   localparam logic [POS_W-1:0] POS_SRC_IP_LAST    = 11'd29;
   localparam logic [POS_W-1:0] POS_SRC_PORT_FIRST = 11'd34;
   localparam logic [POS_W-1:0] POS_SRC_PORT_LAST  = 11'd35;
   localparam logic [POS_W-1:0] POS_DST_PORT_FIRST = 11'd36;
   localparam logic [POS_W-1:0] POS_DST_PORT_LAST  = 11'd37;
   localparam logic [POS_W-1:0] POS_HEADER_LAST    = 11'd41;
   localparam logic [POS_W-1:0] POS_PAYLOAD_START  = 11'd42;

   localparam logic [7:0] ETHERTYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] ETHERTYPE_IPV4_LO = 8'h00;
   localparam logic [7:0] IP_PROTO_UDP      = 8'd17;

   localparam logic [PORT_W-1:0] LISTEN_PORT_RESET = 16'd22223;

   localparam logic CSR_SEL_LISTEN_PORT = 1'b0;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } urf_req_type;

   typedef struct packed {
      logic [7:0]         payload_byte;
      logic               byte_valid;
      logic [IP_W-1:0]    sender_ip;
      logic [PORT_W-1:0]  sender_port;
      logic [COUNT_W-1:0] payload_count;
      logic               last_of_frame;
   } urf_rsp_type;

endpackage

### hw/rtl/urf_csr.sv
// Configuration register block holding the listen port.
`timescale 1ns / 1ps

module urf_csr
   import urf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [PORT_W-1:0]     listen_port
);

   logic [PORT_W-1:0] listen_port_ff;
   logic [PORT_W-1:0] listen_port_in;
   logic              reg_sel;

   assign reg_sel = (paddr[CSR_ADDR_W-1] == CSR_SEL_LISTEN_PORT);

   always_comb begin
      listen_port_in = listen_port_ff;
      if (psel && penable && pwrite && reg_sel) begin
         listen_port_in = pwdata[PORT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_port_ff <= LISTEN_PORT_RESET;
      end else begin
         listen_port_ff <= listen_port_in;
      end
   end

   assign prdata      = reg_sel ? CSR_DATA_W'(listen_port_ff) : '0;
   assign pready      = 1'b1;
   assign listen_port = listen_port_ff;

endmodule

### hw/rtl/urf_front.sv
// Front end: tracks byte position, captures header fields and classifies each byte.
`timescale 1ns / 1ps

module urf_front
   import urf_pkg::*;
#(
   parameter int MAX_COUNT = 2047
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  urf_req_type       req_data,
   input  logic [PORT_W-1:0] listen_port,
   output logic              emit,
   output urf_rsp_type       result
);

   localparam int CNT_W = $clog2(MAX_COUNT + 1);
   localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic [POS_W-1:0]  pos_ff,      pos_in;
   logic              eth_ok_ff,   eth_ok_in;
   logic              proto_ok_ff, proto_ok_in;
   logic [IP_W-1:0]   src_ip_ff,   src_ip_in;
   logic [PORT_W-1:0] src_port_ff, src_port_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;
   logic [CNT_W-1:0]  seen_ff,     seen_in;
   logic [EXT_W-1:0]  seen_ext;
   logic [7:0]        data_byte;
   logic              eof;
   logic              match;
   logic              in_payload;
   logic              empty_payload;

   assign data_byte = req_data.frame_byte;
   assign eof       = req_data.end_of_frame;

   always_comb begin
      eth_ok_in   = eth_ok_ff;
      proto_ok_in = proto_ok_ff;
      src_ip_in   = src_ip_ff;
      src_port_in = src_port_ff;
      dst_port_in = dst_port_ff;
      case (pos_ff) inside
         POS_ETH_HI: begin
            eth_ok_in = (data_byte == ETHERTYPE_IPV4_HI);
         end
         POS_ETH_LO: begin
            eth_ok_in = eth_ok_ff && (data_byte == ETHERTYPE_IPV4_LO);
         end
         POS_PROTO: begin
            proto_ok_in = (data_byte == IP_PROTO_UDP);
         end
         [POS_SRC_IP_FIRST:POS_SRC_IP_LAST]: begin
            src_ip_in = {src_ip_ff[IP_W-9:0], data_byte};
         end
         [POS_SRC_PORT_FIRST:POS_SRC_PORT_LAST]: begin
            src_port_in = {src_port_ff[PORT_W-9:0], data_byte};
         end
         [POS_DST_PORT_FIRST:POS_DST_PORT_LAST]: begin
            dst_port_in = {dst_port_ff[PORT_W-9:0], data_byte};
         end
         default: begin
         end
      endcase

      match         = eth_ok_in && proto_ok_in && (dst_port_in == listen_port);
      in_payload    = (pos_ff >= POS_PAYLOAD_START);
      empty_payload = (pos_ff == POS_HEADER_LAST) && eof;

      seen_in = seen_ff;
      if (match && in_payload && (seen_ff < CNT_W'(MAX_COUNT))) begin
         seen_in = seen_ff + CNT_W'(1);
      end
      seen_ext = EXT_W'(seen_in);

      emit = accept && match && (in_payload || empty_payload);

      result.sender_ip     = src_ip_in;
      result.sender_port   = src_port_in;
      result.last_of_frame = eof;
      if (in_payload) begin
         result.payload_byte  = data_byte;
         result.byte_valid    = 1'b1;
         result.payload_count = seen_ext[COUNT_W-1:0];
      end else begin
         result.payload_byte  = '0;
         result.byte_valid    = 1'b0;
         result.payload_count = '0;
      end

      pos_in = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         eth_ok_ff   <= 1'b0;
         proto_ok_ff <= 1'b0;
         src_ip_ff   <= '0;
         src_port_ff <= '0;
         dst_port_ff <= '0;
         seen_ff     <= '0;
      end else if (accept) begin
         if (eof) begin
            pos_ff      <= '0;
            eth_ok_ff   <= 1'b0;
            proto_ok_ff <= 1'b0;
            src_ip_ff   <= '0;
            src_port_ff <= '0;
            dst_port_ff <= '0;
            seen_ff     <= '0;
         end else begin
            pos_ff      <= pos_in;
            eth_ok_ff   <= eth_ok_in;
            proto_ok_ff <= proto_ok_in;
            src_ip_ff   <= src_ip_in;
            src_port_ff <= src_port_in;
            dst_port_ff <= dst_port_in;
            seen_ff     <= seen_in;
         end
      end
   end

endmodule

### hw/rtl/urf_queue.sv
// Result queue between the classifying front end and the result port.
`timescale 1ns / 1ps

module urf_queue
   import urf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  urf_rsp_type wr_data,
   input  logic        rd_en,
   output urf_rsp_type rd_data,
   output logic        full,
   output logic        empty
);

   urf_rsp_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff,  count_in;
   logic                     do_wr;
   logic                     do_rd;

   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];

endmodule

### hw/rtl/udp_port_receive_filter.sv
// Top level of the UDP port receive filter.
// Usage:
//  - Input queue port: drive req_data with one frame byte and its end-of-frame
//    marker and raise push; a transaction completes when push is high and
//    full is low. One byte can be taken every clock cycle while full is low.
//  - Result queue port: while empty is low, rsp_data holds the oldest result;
//    raise pop to take it. Results are the payload bytes (offset 42 on) of
//    frames with ethertype IPv4, protocol UDP and the configured destination
//    port, or one empty marker result for a matching frame with no payload.
//  - A result is visible in the cycle after the byte that causes it is taken.
//    Throughput is one byte per cycle while full is low; the front end is combinational.
//  - A four-entry result queue decouples the sides: when the receiver stalls,
//    bytes are still taken until the queue fills, then full stays high.
//  - Configuration port: APB writes to addresses 0 to 3 (paddr[2] low) set the
//    listen port (reset value 22223); pready is always high.
//  - Reset clears the frame state, empties the queue and restores the port.
`timescale 1ns / 1ps

module udp_port_receive_filter
   import urf_pkg::*;
#(
   parameter int MAX_COUNT = 2047
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  urf_req_type           req_data,
   output logic                  empty,
   input  logic                  pop,
   output urf_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic              accept;
   logic              emit;
   urf_rsp_type       front_result;
   logic [PORT_W-1:0] listen_port;

   assign accept = push && !full;

   urf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .listen_port (listen_port)
   );

   urf_front #(
      .MAX_COUNT (MAX_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .listen_port (listen_port),
      .emit        (emit),
      .result      (front_result)
   );

   urf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (emit),
      .wr_data (front_result),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .full    (full),
      .empty   (empty)
   );

   assert property (@(posedge clock) disable iff (reset) !(full && empty))
      else $error("result queue reports full and empty together");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !emit) |=> !full)
      else $error("result queue full after a pop with no new result");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.byte_valid) |->
         (rsp_data.last_of_frame && (rsp_data.payload_count == '0)))
      else $error("empty payload result is not a final zero-count result");

endmodule
